### rtl/lpr_pkg.sv
// shared types for the longest prefix route lookup block
package lpr_pkg;

  // input word: one route write or one address lookup
  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic        slot_valid;
    logic [31:0] route_dest;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [2:0]  route_port;
    logic [31:0] lookup_addr;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        hit;
    logic        write_done;
    logic [3:0]  best_slot;
    logic [2:0]  out_port;
    logic [31:0] next_hop;
  } out_word_t;

  // one stored route
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [2:0]  port;
  } route_t;

  // command code of the input word
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // take the input word, write the table on a write command
    logic rd;        // read the current scan slot and step the scan counter
    logic out_load;  // form the result word
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;  // scan counter sits on the last slot
  } sts_t;

endpackage

### rtl/longest_prefix_route_lookup.sv
// longest prefix match ipv4 route table, top level
// a lookup scans one slot per cycle from the table memory read port, then passes the
// compare and result states to a registered strobe; no new word is taken until idle
// a route write is stored at accept, then strobed after the result state
// results show for one cycle on out_valid and the receiver cannot stall
// synchronous active-low reset clears the valid bits and control; table data is unreset
module longest_prefix_route_lookup #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lpr_pkg::in_word_t  in_word,
  output logic               out_valid,
  output lpr_pkg::out_word_t out_word
);

  lpr_pkg::ctl_t ctl;
  lpr_pkg::sts_t sts;

  // sequencer
  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_word.cmd),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // table and match logic
  lpr_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_word  (in_word),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

### rtl/lpr_ctrl.sv
// controller state machine: accept, table scan and result strobe
module lpr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_cmd,
  input  lpr_pkg::sts_t sts,
  output lpr_pkg::ctl_t ctl,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // commands follow the state
  always_comb begin
    ctl          = '0;
    ctl.load     = (state_r == S_IDLE) && start;
    ctl.rd       = (state_r == S_SCAN);
    ctl.out_load = (state_r == S_RESULT);
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_cmd == lpr_pkg::CMD_WRITE) ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and strobe registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  // a strobe only ever follows the result state
  a_strobe_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_RESULT))
    else $error("result strobe without result state");

  // an accepted lookup starts a scan
  a_lookup_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load && (in_cmd == lpr_pkg::CMD_LOOKUP)) |=> (state_r == S_SCAN))
    else $error("lookup did not start a scan");

  // an accepted write is answered without a scan
  a_write_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load && (in_cmd == lpr_pkg::CMD_WRITE)) |=> (state_r == S_RESULT))
    else $error("write did not go straight to the result");

  // the scan ends on the last slot
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.scan_last) |=> (state_r == S_CMP))
    else $error("scan ran past the last slot");
`endif

endmodule

### rtl/lpr_datapath.sv
// route table memory, valid bits, scan counter and best-match registers
module lpr_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpr_pkg::ctl_t     ctl,
  input  lpr_pkg::in_word_t in_word,
  output lpr_pkg::sts_t     sts,
  output lpr_pkg::out_word_t out_word
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // route table and valid bits
  lpr_pkg::route_t  route_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  // captured word fields
  logic        cmd_r;
  logic [31:0] addr_r;

  // scan counter and registered read
  logic [IW-1:0]   scan_idx_r;
  lpr_pkg::route_t rd_route_r;
  logic            rd_valid_r;
  logic [IW-1:0]   rd_idx_r;
  logic            cmp_en_r;

  // best match so far
  logic            found_r;
  logic [31:0]     win_mask_r;
  logic [31:0]     best_gw_r;
  logic [2:0]      best_port_r;
  logic [IW-1:0]   best_idx_r;

  lpr_pkg::out_word_t out_word_r, out_word_nxt;

  logic [8:0]    slot_w;
  logic          wr_ok;
  logic [IW-1:0] wr_idx;
  logic          wr_en;
  logic          match;
  logic          better;
  logic [8:0]    best_idx_w;

  // write address check: slots at or past the table depth are dropped
  assign slot_w = {5'b0, in_word.slot};
  assign wr_ok  = (slot_w < 9'(ENTRIES));
  assign wr_idx = slot_w[IW-1:0];
  assign wr_en  = ctl.load && (in_word.cmd == lpr_pkg::CMD_WRITE) && wr_ok;

  // table write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      route_mem[wr_idx] <= '{dest:    in_word.route_dest,
                             mask:    in_word.route_mask,
                             gateway: in_word.route_gateway,
                             port:    in_word.route_port};
    end
  end

  // table read, one slot per cycle
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_route_r <= route_mem[scan_idx_r];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= in_word.slot_valid;
    end
  end

  // scan counter and compare enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_en_r   <= 1'b0;
    end else begin
      cmp_en_r <= ctl.rd;
      if (ctl.load) begin
        scan_idx_r <= '0;
      end else if (ctl.rd) begin
        scan_idx_r <= scan_idx_r + IW'(1);
      end
    end
  end

  assign sts.scan_last = (scan_idx_r == IW'(ENTRIES - 1));

  // slot tag and valid bit travel with the read data
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_valid_r <= valid_r[scan_idx_r];
      rd_idx_r   <= scan_idx_r;
    end
  end

  // capture the word on accept
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_word.cmd;
      addr_r <= in_word.lookup_addr;
    end
  end

  // prefix match and priority: numerically greater mask wins, first slot wins a tie
  assign match  = rd_valid_r &&
                  (((addr_r ^ rd_route_r.dest) & rd_route_r.mask) == 32'd0);
  assign better = !found_r || (rd_route_r.mask > win_mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.load) begin
      found_r <= 1'b0;
    end else if (cmp_en_r && match && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en_r && match && better) begin
      win_mask_r  <= rd_route_r.mask;
      best_gw_r   <= rd_route_r.gateway;
      best_port_r <= rd_route_r.port;
      best_idx_r  <= rd_idx_r;
    end
  end

  // result word
  assign best_idx_w = 9'(best_idx_r);

  always_comb begin
    out_word_nxt = '0;
    if (cmd_r == lpr_pkg::CMD_WRITE) begin
      out_word_nxt.write_done = 1'b1;
    end else if (found_r) begin
      out_word_nxt.hit       = 1'b1;
      out_word_nxt.best_slot = best_idx_w[3:0];
      out_word_nxt.out_port  = best_port_r;
      out_word_nxt.next_hop  = (best_gw_r != 32'd0) ? best_gw_r : addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_word = out_word_r;

endmodule

### verif/longest_prefix_route_lookup_tb.sv
// testbench for the longest prefix route lookup block: directed and random route traffic
`timescale 1ns / 100ps

module longest_prefix_route_lookup_tb;

  localparam int ENTRIES = 16;
  localparam int DRAIN_LIMIT = 1000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  lpr_pkg::in_word_t  in_word;
  logic               out_valid;
  lpr_pkg::out_word_t out_word;

  // shadow route table of the testbench
  lpr_pkg::route_t    route_shadow [ENTRIES];
  logic               route_live [ENTRIES];
  lpr_pkg::out_word_t route_results_due [$];
  logic [31:0]        net_base [4];
  int                 route_errors = 0;

  longest_prefix_route_lookup #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // apply one accepted word to the shadow table and form its result word
  function automatic lpr_pkg::out_word_t route_table_step(input lpr_pkg::in_word_t w);
    lpr_pkg::out_word_t r;
    logic [31:0]        top_mask;
    int                 best;
    bit                 found;
    r = '0;
    top_mask = '0;
    best = 0;
    found = 1'b0;
    if (w.cmd == lpr_pkg::CMD_WRITE) begin
      if (w.slot < ENTRIES) begin
        route_shadow[w.slot] = '{w.route_dest, w.route_mask, w.route_gateway, w.route_port};
        route_live[w.slot] = w.slot_valid;
      end
      r.write_done = 1'b1;
    end else begin
      // greatest mask wins, the lowest slot keeps a tie
      for (int i = 0; i < ENTRIES; i++) begin
        if (route_live[i] &&
            ((w.lookup_addr & route_shadow[i].mask) ==
             (route_shadow[i].dest & route_shadow[i].mask)) &&
            (!found || route_shadow[i].mask > top_mask)) begin
          found = 1'b1;
          best = i;
          top_mask = route_shadow[i].mask;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.best_slot = 4'(best);
        r.out_port = route_shadow[best].port;
        r.next_hop = (route_shadow[best].gateway != 0) ? route_shadow[best].gateway
                                                       : w.lookup_addr;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch in %s: expected %h, actual %h", $time, name, want, got);
      route_errors++;
    end
  endtask

  // result checking and prediction of each accepted word
  always @(posedge clk) begin : route_scoreboard
    lpr_pkg::out_word_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (route_results_due.size() == 0) begin
          $display("%0t unexpected result word: expected none, actual %h", $time, out_word);
          route_errors++;
        end else begin
          want = route_results_due.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_word.hit));
          check_field("write_done", 32'(want.write_done), 32'(out_word.write_done));
          check_field("best_slot", 32'(want.best_slot), 32'(out_word.best_slot));
          check_field("out_port", 32'(want.out_port), 32'(out_word.out_port));
          check_field("next_hop", want.next_hop, out_word.next_hop);
        end
      end
      if (start && !busy) begin
        route_results_due.push_back(route_table_step(in_word));
      end
    end
  end

  function automatic lpr_pkg::in_word_t route_write(input logic [3:0] slot, input logic valid,
                                                    input logic [31:0] dest,
                                                    input logic [31:0] mask,
                                                    input logic [31:0] gateway,
                                                    input logic [2:0] port);
    lpr_pkg::in_word_t w;
    w.cmd = lpr_pkg::CMD_WRITE;
    w.slot = slot;
    w.slot_valid = valid;
    w.route_dest = dest;
    w.route_mask = mask;
    w.route_gateway = gateway;
    w.route_port = port;
    w.lookup_addr = $urandom;
    return w;
  endfunction

  function automatic lpr_pkg::in_word_t route_lookup(input logic [31:0] addr);
    lpr_pkg::in_word_t w;
    w.cmd = lpr_pkg::CMD_LOOKUP;
    w.slot = 4'($urandom_range(0, 15));
    w.slot_valid = 1'($urandom_range(0, 1));
    w.route_dest = $urandom;
    w.route_mask = $urandom;
    w.route_gateway = $urandom;
    w.route_port = 3'($urandom_range(0, 7));
    w.lookup_addr = addr;
    return w;
  endfunction

  // random word: route writes, mostly prefix routes around four nearby networks, and lookups, often into them
  function automatic lpr_pkg::in_word_t random_route_word();
    lpr_pkg::in_word_t w;
    int                len;
    int                pick;
    w = route_lookup($urandom);
    if ($urandom_range(0, 2) == 0) begin
      w.cmd = lpr_pkg::CMD_WRITE;
      w.slot_valid = ($urandom_range(0, 6) != 0);
      if ($urandom_range(0, 9) != 0) begin
        len = $urandom_range(0, 32);
        w.route_mask = (len == 0) ? 32'h0 : (~32'h0 << (32 - len));
        w.route_dest = (net_base[$urandom_range(0, 3)] & w.route_mask) |
                       ($urandom & ~w.route_mask);
      end
      if ($urandom_range(0, 2) == 0) begin
        w.route_gateway = '0;
      end
    end else begin
      pick = $urandom_range(0, ENTRIES - 1);
      if ($urandom_range(0, 3) != 0 && route_live[pick]) begin
        w.lookup_addr = (route_shadow[pick].dest & route_shadow[pick].mask) |
                        ($urandom & ~route_shadow[pick].mask);
      end else if ($urandom_range(0, 1) == 0) begin
        w.lookup_addr = net_base[$urandom_range(0, 3)] ^ 32'($urandom_range(0, 255));
      end
    end
    return w;
  endfunction

  // hold start high until the block takes the word
  task automatic send_word(input lpr_pkg::in_word_t w);
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender idle burst, sometimes placed right where the block turns ready
  task automatic pause_sender();
    start <= 1'b0;
    if ($urandom_range(0, 1) == 0) begin
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    repeat ($urandom_range(1, 3)) @(posedge clk);
  endtask

  // stop sending until every due result word has come back
  task automatic drain_results();
    int n;
    start <= 1'b0;
    @(posedge clk);
    for (n = 0; n < DRAIN_LIMIT && route_results_due.size() > 0; n++) @(posedge clk);
    if (route_results_due.size() > 0) begin
      $display("%0t %0d result words never arrived: expected %h, actual none",
               $time, route_results_due.size(), route_results_due[0]);
      route_errors++;
      route_results_due.delete();
    end
  endtask

  task automatic test_empty_table();
    send_word(route_lookup(32'h0000_0000));
    send_word(route_lookup(32'hffff_ffff));
  endtask

  task automatic test_default_route();
    send_word(route_write(4'd15, 1'b1, 32'h1234_5678, 32'h0, 32'h0a00_0001, 3'd7));
    send_word(route_lookup($urandom));
    send_word(route_write(4'd0, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 3'd0));
    send_word(route_lookup(32'hffff_ffff));
  endtask

  task automatic test_longest_match();
    send_word(route_write(4'd3, 1'b1, 32'h0a01_0000, 32'hffff_0000, 32'hffff_ffff, 3'd3));
    send_word(route_write(4'd5, 1'b1, 32'h0a01_ffff, 32'hffff_0000, 32'h0a00_0002, 3'd5));
    // equal masks: the lower slot keeps the route
    send_word(route_lookup(32'h0a01_abcd));
    send_word(route_write(4'd4, 1'b1, 32'h0a01_0100, 32'hffff_ff00, 32'h0, 3'd4));
    send_word(route_lookup(32'h0a01_01ff));
    // non-contiguous mask compared by its numeric value
    send_word(route_write(4'd2, 1'b1, 32'h0a01_0000, 32'hffff_00ff, 32'h0a00_0003, 3'd2));
    send_word(route_lookup(32'h0a01_ab00));
  endtask

  task automatic test_route_removal();
    send_word(route_write(4'd4, 1'b0, 32'h0a01_0100, 32'hffff_ff00, 32'h0, 3'd4));
    send_word(route_lookup(32'h0a01_01ff));
    send_word(route_write(4'd15, 1'b0, 32'h0, 32'h0, 32'h0, 3'd0));
    send_word(route_lookup(32'h0102_0304));
    // a route stored without its valid mark stays unused
    send_word(route_write(4'd9, 1'b0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 3'd7));
    send_word(route_lookup(32'hffff_ffff));
    drain_results();
  endtask

  task automatic test_random_routes(input int count, input bit with_gaps);
    net_base[0] = $urandom;
    for (int i = 1; i < 4; i++) begin
      net_base[i] = net_base[0] ^ (32'h1 << $urandom_range(0, 31));
    end
    for (int i = 0; i < count; i++) begin
      send_word(random_route_word());
      if (with_gaps && $urandom_range(0, 3) == 0) begin
        pause_sender();
      end
    end
  endtask

  // test sequence
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      route_live[i] = 1'b0;
      route_shadow[i] = '0;
    end
    rst_n <= 1'b0;
    start <= 1'b0;
    in_word <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_default_route();
    test_longest_match();
    test_route_removal();
    test_random_routes(750, 1'b1);
    drain_results();
    test_random_routes(300, 1'b0);
    drain_results();
    repeat (ENTRIES + 3) @(posedge clk);
    if (route_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run time guard
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
rtl/lpr_pkg.sv
rtl/lpr_ctrl.sv
rtl/lpr_datapath.sv
rtl/longest_prefix_route_lookup.sv
verif/longest_prefix_route_lookup_tb.sv
